// ----- hw/rtl/per_task_cpu_usage_profiler_top_assert.svh -----
// assertion macros for the profiler top level
`ifndef PER_TASK_CPU_USAGE_PROFILER_TOP_ASSERT_SVH
`define PER_TASK_CPU_USAGE_PROFILER_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define PTCU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define PTCU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ptcu_pkg.sv -----
package ptcu_pkg;

    // table size and field widths
    localparam int SLOTS      = 16;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ID_W       = 32;
    localparam int IDX_W      = 4;
    localparam int SHARE_W    = 14;
    localparam int PROD_W     = ID_W + SHARE_W;
    localparam int IN_DATA_W  = 4 * ID_W;
    localparam int OUT_FLD_W  = IDX_W + ID_W + SHARE_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    localparam logic [SHARE_W-1:0] FULL_SCALE  = 14'd10000;
    localparam logic [ID_W-1:0]    STALE_RESET = 32'd10000;

    // datapath operations
    typedef logic [3:0] op_t;
    localparam op_t OP_NONE      = 4'd0;
    localparam op_t OP_LOAD      = 4'd1;
    localparam op_t OP_SCAN_FROM = 4'd2;
    localparam op_t OP_UPD_FROM  = 4'd3;
    localparam op_t OP_SCAN_TO   = 4'd4;
    localparam op_t OP_UPD_TO    = 4'd5;
    localparam op_t OP_STALE     = 4'd6;
    localparam op_t OP_MUL       = 4'd7;
    localparam op_t OP_DIV_START = 4'd8;
    localparam op_t OP_EMIT      = 4'd9;

    typedef logic [SLOT_W-1:0] slot_idx_t;

    typedef struct packed {
        op_t       op;
        slot_idx_t idx;
    } ptcu_cmd_t;

    typedef struct packed {
        logic req_period;
        logic from_nz;
        logic to_nz;
        logic skip_div;
        logic div_done;
        logic out_free;
    } ptcu_stat_t;

endpackage

// ----- hw/rtl/ptcu_div.sv -----
// restoring divider, one quotient bit per cycle, quotient known to fit SHARE_W bits
module ptcu_div
    import ptcu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [PROD_W-1:0]  numer,
    input  logic [ID_W-1:0]    denom,
    output logic               done,
    output logic [SHARE_W-1:0] quot
);

    localparam int CNT_W = $clog2(SHARE_W);

    logic               run_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [ID_W-1:0]    rem_reg;
    logic [SHARE_W-1:0] low_reg;
    logic [SHARE_W-1:0] q_reg;

    logic [ID_W:0]      trial;
    logic               q_bit;
    logic [ID_W-1:0]    rem_next;

    // trial subtract of the shifted remainder
    always_comb
    begin
        trial    = {rem_reg, low_reg[SHARE_W-1]};
        q_bit    = (trial >= {1'b0, denom});
        rem_next = q_bit ? ID_W'(trial - {1'b0, denom}) : trial[ID_W-1:0];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(SHARE_W - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= numer[PROD_W-1:SHARE_W];
            low_reg <= numer[SHARE_W-1:0];
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[SHARE_W-2:0], 1'b0};
            q_reg   <= {q_reg[SHARE_W-2:0], q_bit};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ----- hw/rtl/ptcu_dp.sv -----
// slot table, period total, share computation and result register
module ptcu_dp
    import ptcu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ptcu_cmd_t             cmd,
    output ptcu_stat_t            stat,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic                  in_kind,
    input  logic                  cfg_valid,
    input  logic [ID_W-1:0]       cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic                  out_last
);

    logic [ID_W-1:0] tag_reg   [SLOTS];
    logic [ID_W-1:0] start_reg [SLOTS];
    logic [ID_W-1:0] busy_reg  [SLOTS];
    logic [ID_W-1:0] leave_reg [SLOTS];

    logic [ID_W-1:0] timeout_reg;

    // latched item
    logic            req_reg;
    logic [ID_W-1:0] from_reg;
    logic [ID_W-1:0] to_reg;
    logic [ID_W-1:0] stamp_reg;
    logic [ID_W-1:0] tick_reg;

    // search results
    logic            hit_reg;
    logic            emp_reg;
    slot_idx_t       hit_idx_reg;
    slot_idx_t       emp_idx_reg;
    logic [ID_W-1:0] hit_start_reg;
    logic [ID_W-1:0] hit_busy_reg;

    // period arithmetic
    logic [ID_W-1:0]   total_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              zero_reg;
    logic              cap_reg;

    // result register
    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic [ID_W-1:0]    out_tag_reg;
    logic [SHARE_W-1:0] out_share_reg;
    logic               out_last_reg;

    logic [ID_W-1:0]    rd_tag;
    logic [ID_W-1:0]    rd_start;
    logic [ID_W-1:0]    rd_busy;
    logic [ID_W-1:0]    rd_leave;
    logic [ID_W-1:0]    key;
    logic               key_hit;
    logic               upd_ok;
    slot_idx_t          tgt_idx;
    logic [ID_W-1:0]    busy_new;
    logic               stale;
    logic               div_done;
    logic [SHARE_W-1:0] div_quot;
    logic [SHARE_W-1:0] share;

    // one read port at the command index
    always_comb
    begin
        rd_tag   = tag_reg[cmd.idx];
        rd_start = start_reg[cmd.idx];
        rd_busy  = busy_reg[cmd.idx];
        rd_leave = leave_reg[cmd.idx];
        key      = (cmd.op == OP_SCAN_TO) ? to_reg : from_reg;
        key_hit  = (rd_tag == key);
        upd_ok   = hit_reg | emp_reg;
        tgt_idx  = hit_reg ? hit_idx_reg : emp_idx_reg;
        busy_new = (hit_reg ? hit_busy_reg : '0)
                 + (stamp_reg - (hit_reg ? hit_start_reg : '0));
        stale    = ((tick_reg - rd_leave) >= timeout_reg);
        share    = zero_reg ? '0 : (cap_reg ? FULL_SCALE : div_quot);
    end

    // table, flags and config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                tag_reg[i]   <= '0;
                start_reg[i] <= '0;
                busy_reg[i]  <= '0;
                leave_reg[i] <= '0;
            end
            timeout_reg   <= STALE_RESET;
            hit_reg       <= 1'b0;
            emp_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                timeout_reg <= cfg_data;
            end
            // result word valid: set on a report, cleared when taken
            if (cmd.op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_LOAD, OP_UPD_FROM, OP_UPD_TO:
                begin
                    hit_reg <= 1'b0;
                    emp_reg <= 1'b0;
                    if (cmd.op == OP_UPD_FROM && upd_ok)
                    begin
                        tag_reg[tgt_idx]   <= from_reg;
                        busy_reg[tgt_idx]  <= busy_new;
                        leave_reg[tgt_idx] <= tick_reg;
                    end
                    if (cmd.op == OP_UPD_TO && upd_ok)
                    begin
                        tag_reg[tgt_idx]   <= to_reg;
                        start_reg[tgt_idx] <= stamp_reg;
                    end
                end
                OP_SCAN_FROM, OP_SCAN_TO:
                begin
                    if (key_hit)
                    begin
                        hit_reg <= 1'b1;
                    end
                    if (rd_tag == '0)
                    begin
                        emp_reg <= 1'b1;
                    end
                end
                OP_STALE:
                begin
                    if (stale)
                    begin
                        tag_reg[cmd.idx]   <= '0;
                        start_reg[cmd.idx] <= '0;
                        busy_reg[cmd.idx]  <= '0;
                        leave_reg[cmd.idx] <= '0;
                    end
                end
                OP_EMIT:
                begin
                    busy_reg[cmd.idx] <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                req_reg   <= in_kind;
                from_reg  <= in_data[ID_W-1:0];
                to_reg    <= in_data[2*ID_W-1:ID_W];
                stamp_reg <= in_data[3*ID_W-1:2*ID_W];
                tick_reg  <= in_data[4*ID_W-1:3*ID_W];
                total_reg <= '0;
            end
            OP_SCAN_FROM, OP_SCAN_TO:
            begin
                // tags are unique, so the first match is the only one
                if (key_hit && !hit_reg)
                begin
                    hit_idx_reg   <= cmd.idx;
                    hit_start_reg <= rd_start;
                    hit_busy_reg  <= rd_busy;
                end
                if (rd_tag == '0 && !emp_reg)
                begin
                    emp_idx_reg <= cmd.idx;
                end
            end
            OP_STALE:
            begin
                total_reg <= total_reg + (stale ? '0 : rd_busy);
            end
            OP_MUL:
            begin
                prod_reg <= PROD_W'(rd_busy) * PROD_W'(FULL_SCALE);
                zero_reg <= (total_reg == '0);
                cap_reg  <= (rd_busy >= total_reg);
            end
            OP_EMIT:
            begin
                out_idx_reg   <= IDX_W'(cmd.idx);
                out_tag_reg   <= rd_tag;
                out_share_reg <= share;
                out_last_reg  <= (cmd.idx == SLOT_W'(SLOTS - 1));
            end
            default:
            begin
            end
        endcase
    end

    ptcu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_DIV_START),
        .numer (prod_reg),
        .denom (total_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // status to the controller
    always_comb
    begin
        stat.req_period = req_reg;
        stat.from_nz    = (from_reg != '0);
        stat.to_nz      = (to_reg != '0);
        stat.skip_div   = zero_reg | cap_reg;
        stat.div_done   = div_done;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = OUT_DATA_W'({out_share_reg, out_tag_reg, out_idx_reg});
    assign out_last  = out_last_reg;

endmodule

// ----- hw/rtl/ptcu_ctrl.sv -----
// sequencer: walks the slots for searches, stale clearing and reports
module ptcu_ctrl
    import ptcu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ptcu_stat_t stat,
    output ptcu_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DEC    = 4'd1;
    localparam logic [3:0] ST_FSCAN  = 4'd2;
    localparam logic [3:0] ST_FUPD   = 4'd3;
    localparam logic [3:0] ST_TSCAN  = 4'd4;
    localparam logic [3:0] ST_TUPD   = 4'd5;
    localparam logic [3:0] ST_STALE  = 4'd6;
    localparam logic [3:0] ST_MUL    = 4'd7;
    localparam logic [3:0] ST_DSTART = 4'd8;
    localparam logic [3:0] ST_DWAIT  = 4'd9;
    localparam logic [3:0] ST_EMIT   = 4'd10;

    localparam slot_idx_t LAST_SLOT = SLOT_W'(SLOTS - 1);

    logic [3:0] state_reg;
    logic [3:0] state_next;
    slot_idx_t  idx_reg;
    slot_idx_t  idx_next;
    logic       at_last;

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd.op     = OP_NONE;
        cmd.idx    = idx_reg;
        at_last    = (idx_reg == LAST_SLOT);
        in_ready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    idx_next   = '0;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                priority if (stat.req_period)
                    state_next = ST_STALE;
                else if (stat.from_nz)
                    state_next = ST_FSCAN;
                else if (stat.to_nz)
                    state_next = ST_TSCAN;
                else
                    state_next = ST_IDLE;
            end
            ST_FSCAN:
            begin
                cmd.op = OP_SCAN_FROM;
                if (at_last)
                begin
                    idx_next   = '0;
                    state_next = ST_FUPD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_FUPD:
            begin
                cmd.op     = OP_UPD_FROM;
                state_next = stat.to_nz ? ST_TSCAN : ST_IDLE;
            end
            ST_TSCAN:
            begin
                cmd.op = OP_SCAN_TO;
                if (at_last)
                begin
                    idx_next   = '0;
                    state_next = ST_TUPD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_TUPD:
            begin
                cmd.op     = OP_UPD_TO;
                state_next = ST_IDLE;
            end
            ST_STALE:
            begin
                cmd.op = OP_STALE;
                if (at_last)
                begin
                    idx_next   = '0;
                    state_next = ST_MUL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                if (stat.skip_div)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.op     = OP_DIV_START;
                    state_next = ST_DWAIT;
                end
            end
            ST_DWAIT:
            begin
                if (stat.div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op = OP_EMIT;
                    if (at_last)
                    begin
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ----- hw/rtl/per_task_cpu_usage_profiler_top.sv -----
// channel   | signals                          | word
// ----------+----------------------------------+------------------------------------------
// s_axis    | tvalid tready tdata tuser        | switch or period-end request
// m_axis    | tvalid tready tdata tlast        | one slot report, tlast on the final slot
// cfg       | cfg_valid cfg_ready cfg_data     | stale_timeout
//
// a context switch searches the table one slot per cycle for each nonzero tag and then
// updates the matching slot, or an empty one if the tag is not yet in the table
// a period end clears stale slots while summing the total, then for each slot
// multiplies, runs the 14-step divider and reports; zero total or a capped share skips it
// reset clears the table to all empty and stale_timeout to 10000
// a stalled m_axis holds the report sequence; s_axis is accepted only between requests
module per_task_cpu_usage_profiler_top
    import ptcu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // from_id [31:0], to_id [63:32], cycle_stamp [95:64], tick_now [127:96]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type [0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // slot_index [3:0], task_id [35:4], usage_hundredths [49:36], zero fill above
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [ID_W-1:0]       cfg_data
);

`include "per_task_cpu_usage_profiler_top_assert.svh"

    ptcu_cmd_t  dp_cmd;
    ptcu_stat_t dp_stat;

    assign cfg_ready = 1'b1;

    ptcu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    ptcu_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .in_data   (s_axis_tdata),
        .in_kind   (s_axis_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

    // checks
    `PTCU_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while previous one in progress")
    `PTCU_ASSERT_SAME(a_emit_no_overwrite, dp_cmd.op == OP_EMIT, !m_axis_tvalid || m_axis_tready, "report overwrites a pending word")
    `PTCU_ASSERT_SAME(a_share_range, m_axis_tvalid, m_axis_tdata[49:36] <= FULL_SCALE, "usage above full scale")

endmodule
